FILE: design/rational_accumulator_defines.svh
// Assertion macros for the rational accumulator.
// Depends on nothing; included by the top level only.
`ifndef RATIONAL_ACCUMULATOR_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_DEFINES_SVH
// Assert that an antecedent implies a consequent in the next cycle.
`define RA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rational_accumulator next-cycle check failed");
// Assert a condition that holds at every edge outside reset.
`define RA_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("rational_accumulator check failed");
`endif

FILE: design/ra_pkg.sv
// Package for the rational accumulator: request kinds.
// Depends on nothing.
package ra_pkg;
  localparam logic [1:0] REQ_LOAD = 2'd0;
  localparam logic [1:0] REQ_ADD  = 2'd1;
  localparam logic [1:0] REQ_MUL  = 2'd2;
  localparam logic [1:0] REQ_NONE = 2'd3;
endpackage

FILE: design/rational_accumulator.sv
// Rational accumulator top level: sequencer, shared multiplier and divider.
// Depends on ra_pkg and rational_accumulator_defines.svh.
//
// The block holds one signed fraction, 1/1 after reset. Each transaction on
// s_axis loads, adds or multiplies an operand fraction, or with REQ_NONE
// returns the held value (tuser = kind). The operand is first reduced by a
// truncating Euclidean GCD, an add or multiply is done with wrapping
// WORD_BITS-bit products taken one at a time from a single shared multiplier,
// and the result is reduced again. All divisions run on one shared restoring
// divider that yields one quotient bit a cycle, and the divisions take most
// of the time a transaction needs. When a GCD is zero (value 0/0) the value
// is kept unreduced and the error flag is raised. The block is not ready
// while one transaction is in work; the result waits in the m_axis register
// until it is taken.
`include "rational_accumulator_defines.svh"
module rational_accumulator #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // tdata: operand_num [W-1:0], operand_denom [2W-1:W], zero filled to bytes
  input  logic [((2*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type [1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // tdata: result_num [W-1:0], result_denom [2W-1:W], zero filled to bytes
  output logic [((2*WORD_BITS+7)/8)*8-1:0] m_axis_tdata,
  // tuser: zero_gcd_error [0]
  output logic                   m_axis_tuser
);
  localparam int W = WORD_BITS;
  localparam int CW = $clog2(W+1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_GCD   = 4'd1;  // start a GCD remainder step
  localparam logic [3:0] S_DIV   = 4'd2;  // divider running
  localparam logic [3:0] S_RDN   = 4'd3;  // divide numerator by g
  localparam logic [3:0] S_RDD   = 4'd4;  // divide denominator by g
  localparam logic [3:0] S_M0    = 4'd5;
  localparam logic [3:0] S_M1    = 4'd6;
  localparam logic [3:0] S_M2    = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;  // return mark: both halves reduced

  logic [3:0]   state;
  logic [3:0]   ret;      // state to resume after a division
  logic         phase;    // 0 reducing operand, 1 reducing result
  logic [1:0]   kind;
  logic [W-1:0] cur_num, cur_denom, opn, opd, n, d, gu, gv, g, p0, p1;
  logic         err;
  // divider
  logic [W-1:0] dv_b, dq, drem;
  logic         dsa, dsb;
  logic [CW-1:0] dcnt;
  logic [W:0]   trial;
  logic [W-1:0] mul_a, mul_b, mul_p;
  logic [W-1:0] qs, rs;

  assign s_axis_tready = (state == S_IDLE) && !m_axis_tvalid;
  assign trial = {drem, dq[W-1]} - {1'b0, dv_b};
  assign mul_p = W'(mul_a * mul_b);
  assign qs = (dsa != dsb) ? -dq : dq;
  assign rs = dsa ? -drem : drem;

  always_comb begin
    case (state)
      S_M0:    begin mul_a = cur_num;   mul_b = (kind == ra_pkg::REQ_ADD) ? opd : opn; end
      S_M1:    begin mul_a = opn;       mul_b = cur_denom; end
      default: begin mul_a = cur_denom; mul_b = opd; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_axis_tvalid <= 1'b0;
      cur_num <= W'(1);
      cur_denom <= W'(1);
    end else begin
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            kind <= s_axis_tuser;
            n <= s_axis_tdata[W-1:0];
            d <= s_axis_tdata[2*W-1:W];
            gu <= s_axis_tdata[W-1:0];
            gv <= s_axis_tdata[2*W-1:W];
            phase <= 1'b0;
            err <= 1'b0;
            state <= (s_axis_tuser == ra_pkg::REQ_NONE) ? S_OUT : S_GCD;
          end
        end
        S_GCD: begin
          if (gv == '0) begin
            g <= gu;
            if (gu == '0) begin
              // The value is 0/0 and stays unreduced.
              err <= phase;
              state <= phase ? S_OUT : S_M0;
              if (phase) begin
                cur_num <= n; cur_denom <= d;
              end else begin
                opn <= n; opd <= d;
              end
            end else begin
              state <= S_RDN;
            end
          end else begin
            dv_b <= gv[W-1] ? -gv : gv; ret <= S_GCD; state <= S_DIV;
            dsa <= gu[W-1]; dsb <= gv[W-1];
            dq <= gu[W-1] ? -gu : gu; drem <= '0;
            dcnt <= CW'(W);
          end
        end
        S_RDN: begin
          dsa <= n[W-1]; dsb <= g[W-1];
          dq <= n[W-1] ? -n : n; drem <= '0; dcnt <= CW'(W);
          dv_b <= g[W-1] ? -g : g;
          ret <= S_RDD; state <= S_DIV;
        end
        S_RDD: begin
          n <= qs;
          dsa <= d[W-1]; dsb <= g[W-1];
          dq <= d[W-1] ? -d : d; drem <= '0; dcnt <= CW'(W);
          ret <= S_FIN; state <= S_DIV;
        end
        S_DIV: begin
          if (dcnt == '0) begin
            if (ret == S_GCD) begin
              gu <= gv; gv <= rs; state <= S_GCD;
            end else if (ret == S_RDD) begin
              state <= S_RDD;
            end else begin
              // both halves reduced
              if (phase) begin
                cur_num <= n; cur_denom <= qs; state <= S_OUT;
              end else begin
                opn <= n; opd <= qs; state <= S_M0;
              end
            end
          end else begin
            dcnt <= dcnt - CW'(1);
            if (!trial[W]) begin
              drem <= trial[W-1:0]; dq <= {dq[W-2:0], 1'b1};
            end else begin
              drem <= {drem[W-2:0], dq[W-1]}; dq <= {dq[W-2:0], 1'b0};
            end
          end
        end
        S_M0: begin
          if (kind == ra_pkg::REQ_LOAD) begin
            n <= opn; d <= opd; gu <= opn; gv <= opd; phase <= 1'b1; state <= S_GCD;
          end else begin
            p0 <= mul_p; state <= S_M1;
          end
        end
        S_M1: begin p1 <= mul_p; state <= S_M2; end
        S_M2: begin
          d <= mul_p; gv <= mul_p;
          n <= (kind == ra_pkg::REQ_ADD) ? p0 + p1 : p0;
          gu <= (kind == ra_pkg::REQ_ADD) ? p0 + p1 : p0;
          phase <= 1'b1; state <= S_GCD;
        end
        S_OUT: begin
          m_axis_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[W-1:0] = cur_num;
    m_axis_tdata[2*W-1:W] = cur_denom;
  end
  assign m_axis_tuser = err;

  `RA_ASSERT_NEXT(a_out_holds, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `RA_ASSERT_ALWAYS(a_busy_not_ready, !(state != S_IDLE && s_axis_tready))
endmodule
